// ===== rtl/ktlbs_pkg.sv =====
// Shared codes and widths for the key table search core.
package ktlbs_pkg;

  localparam int unsigned OP_W  = 2;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned IDX_W = 8;
  localparam int unsigned LEN_W = 9;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LINEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_BINARY = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE     = 2'd2;

endpackage

// ===== rtl/ktlbs_if.sv =====
// Valid/ready channels for request items and result items.
interface ktlbs_item_if #(
  parameter int unsigned KEY_W = 32,
  parameter int unsigned VAL_W = 32
);
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [7:0]       entry_index;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value;

  modport source (output valid, operation, entry_index, key, value, input ready);
  modport sink   (input valid, operation, entry_index, key, value, output ready);
endinterface

interface ktlbs_res_if #(
  parameter int unsigned VAL_W = 32
);
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [7:0]       found_index;
  logic [VAL_W-1:0] found_value;

  modport source (output valid, status, found_index, found_value, input ready);
  modport sink   (input valid, status, found_index, found_value, output ready);
endinterface

// ===== rtl/ktlbs_store.sv =====
// Key and value memories: one write port, one registered read port.
module ktlbs_store #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned KW    = 32,
  parameter int unsigned VW    = 32
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [KW-1:0] wr_key_i,
  input  logic [VW-1:0] wr_val_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [KW-1:0] rd_key_o,
  output logic [VW-1:0] rd_val_o
);

  logic [KW-1:0] key_mem [DEPTH];
  logic [VW-1:0] val_mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
      val_mem[wr_addr_i] <= wr_val_i;
    end
    rd_key_o <= key_mem[rd_addr_i];
    rd_val_o <= val_mem[rd_addr_i];
  end

endmodule

// ===== rtl/key_table_linear_binary_search_core.sv =====
// Key table with insert, linear search and binary search.
// Insert and unused codes go straight to S_DONE, then their result moves to the output register.
// Linear search: reads the L entries in use in order, one memory read per cycle, to the first hit.
// Binary search: read in S_BIN_RD, compare in S_BIN_CMP per probe; miss when low passes high.
// One item at a time; the next item is taken once the last result sits in the output register.
// Reset: asynchronous, clears control state and the length register; memory is not cleared.
module key_table_linear_binary_search_core
  import ktlbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_WIDTH   = 32,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ktlbs_item_if.sink       item_i,
  ktlbs_res_if.source      result_o,
  input  logic             cfg_we_i,
  input  logic [LEN_W-1:0] cfg_wdata_i
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [16:0] DEPTH_C = 17'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LIN,
    S_BIN_RD,
    S_BIN_CMP,
    S_DONE
  } state_e;

  state_e               state_q;
  logic [LEN_W-1:0]     cfg_len_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [LEN_W-1:0]     scan_cnt_q;
  logic                 cmp_vld_q;
  logic [IDX_W-1:0]     cmp_pos_q;
  logic [LEN_W-1:0]     low_q;
  logic [LEN_W-1:0]     high_q;
  logic [IDX_W-1:0]     pos_q;
  logic [ST_W-1:0]      res_status_q;
  logic [IDX_W-1:0]     res_index_q;
  logic [VALUE_WIDTH-1:0] res_value_q;
  logic                 out_valid_q;
  logic [ST_W-1:0]      out_status_q;
  logic [IDX_W-1:0]     out_index_q;
  logic [VALUE_WIDTH-1:0] out_value_q;

  logic [LEN_W-1:0]       len_use;
  logic                   out_free;
  logic                   accept;
  logic                   ins_ok;
  logic                   wr_en;
  logic [LEN_W:0]         mid_sum;
  logic [LEN_W-1:0]       mid;
  logic [LEN_W-1:0]       mid_m1;
  logic [IDX_W-1:0]       probe_pos;
  logic [AW-1:0]          rd_addr;
  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic                   key_eq;
  logic                   key_gt;

  function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] p);
    logic [15:0] ext;
    ext = {8'd0, p};
    return ext[AW-1:0];
  endfunction

  // a length above the depth acts as the depth
  assign len_use = ({8'd0, cfg_len_q} > DEPTH_C) ? DEPTH_C[LEN_W-1:0] : cfg_len_q;

  assign out_free    = !out_valid_q || result_o.ready;
  assign item_i.ready = (state_q == S_IDLE);
  assign accept      = item_i.valid && item_i.ready;

  assign ins_ok = ({1'b0, item_i.entry_index} < cfg_len_q) &&
                  ({9'd0, item_i.entry_index} < DEPTH_C);
  assign wr_en  = accept && (item_i.operation == OP_INSERT) && ins_ok;

  // 1-based midpoint; probe position is mid - 1
  assign mid_sum   = {1'b0, low_q} + {1'b0, high_q};
  assign mid       = mid_sum[LEN_W:1];
  assign mid_m1    = mid - 9'd1;
  assign probe_pos = mid_m1[IDX_W-1:0];

  assign rd_addr = (state_q == S_LIN) ? to_addr(scan_cnt_q[IDX_W-1:0]) : to_addr(probe_pos);

  // shared key comparator
  assign key_eq = (key_q == rd_key);
  assign key_gt = (key_q > rd_key);

  ktlbs_store #(
    .DEPTH(TABLE_DEPTH),
    .AW   (AW),
    .KW   (KEY_WIDTH),
    .VW   (VALUE_WIDTH)
  ) u_store (
    .clk_i    (clk_i),
    .wr_en_i  (wr_en),
    .wr_addr_i(to_addr(item_i.entry_index)),
    .wr_key_i (KEY_WIDTH'(item_i.key)),
    .wr_val_i (VALUE_WIDTH'(item_i.value)),
    .rd_addr_i(rd_addr),
    .rd_key_o (rd_key),
    .rd_val_o (rd_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= '0;
    end else if (cfg_we_i) begin
      cfg_len_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      key_q        <= '0;
      scan_cnt_q   <= '0;
      cmp_vld_q    <= 1'b0;
      cmp_pos_q    <= '0;
      low_q        <= '0;
      high_q       <= '0;
      pos_q        <= '0;
      res_status_q <= ST_OK;
      res_index_q  <= '0;
      res_value_q  <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_OK;
      out_index_q  <= '0;
      out_value_q  <= '0;
    end else begin
      // finished result moves to the output register once it is free
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q  <= 1'b1;
        out_status_q <= res_status_q;
        out_index_q  <= res_index_q;
        out_value_q  <= res_value_q;
      end else if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            key_q <= KEY_WIDTH'(item_i.key);
            unique case (item_i.operation)
              OP_INSERT: begin
                res_status_q <= ins_ok ? ST_OK : ST_RANGE;
                res_index_q  <= '0;
                res_value_q  <= '0;
                state_q      <= S_DONE;
              end
              OP_LINEAR: begin
                scan_cnt_q <= '0;
                cmp_vld_q  <= 1'b0;
                state_q    <= S_LIN;
              end
              OP_BINARY: begin
                low_q   <= 9'd1;
                high_q  <= len_use;
                state_q <= S_BIN_RD;
              end
              default: begin
                res_status_q <= ST_NOT_FOUND;
                res_index_q  <= '0;
                res_value_q  <= '0;
                state_q      <= S_DONE;
              end
            endcase
          end
        end
        S_LIN: begin
          // read of entry n is issued while entry n-1 is compared
          if (cmp_vld_q && key_eq) begin
            res_status_q <= ST_OK;
            res_index_q  <= cmp_pos_q;
            res_value_q  <= rd_val;
            state_q      <= S_DONE;
          end else if (scan_cnt_q < len_use) begin
            cmp_vld_q  <= 1'b1;
            cmp_pos_q  <= scan_cnt_q[IDX_W-1:0];
            scan_cnt_q <= scan_cnt_q + 9'd1;
          end else begin
            res_status_q <= ST_NOT_FOUND;
            res_index_q  <= '0;
            res_value_q  <= '0;
            state_q      <= S_DONE;
          end
        end
        S_BIN_RD: begin
          if (low_q <= high_q) begin
            pos_q   <= probe_pos;
            state_q <= S_BIN_CMP;
          end else begin
            res_status_q <= ST_NOT_FOUND;
            res_index_q  <= '0;
            res_value_q  <= '0;
            state_q      <= S_DONE;
          end
        end
        S_BIN_CMP: begin
          if (key_eq) begin
            res_status_q <= ST_OK;
            res_index_q  <= pos_q;
            res_value_q  <= rd_val;
            state_q      <= S_DONE;
          end else begin
            if (key_gt) begin
              low_q <= {1'b0, pos_q} + 9'd2;
            end else begin
              high_q <= {1'b0, pos_q};
            end
            state_q <= S_BIN_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.status      = out_status_q;
  assign result_o.found_index = out_index_q;
  assign result_o.found_value = out_value_q;

endmodule

// ===== rtl/ktlbs_checker.sv =====
// Port-level checks for the key table search core, bound to the top level.
module ktlbs_checker
  import ktlbs_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             item_valid_i,
  input logic             item_ready_i,
  input logic [OP_W-1:0]  item_op_i,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input logic [ST_W-1:0]  res_status_i,
  input logic [IDX_W-1:0] res_index_i,
  input logic             res_value_zero_i
);

  // a held result stays until taken
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped before it was taken");

  // a waiting result keeps its status and index
  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_status_i) && $stable(res_index_i))
    else $error("result changed while it was waiting");

  // a search keeps the block busy in the cycle after it is taken
  a_search_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_i && item_ready_i && (item_op_i == OP_LINEAR || item_op_i == OP_BINARY)
    |=> !item_ready_i)
    else $error("item taken while a search is in progress");

  // a result that is not a hit carries zero index and value
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_status_i != ST_OK |-> res_index_i == '0 && res_value_zero_i)
    else $error("non-zero payload on a miss or range error");

endmodule

bind key_table_linear_binary_search_core ktlbs_checker u_ktlbs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .item_valid_i    (item_i.valid),
  .item_ready_i    (item_i.ready),
  .item_op_i       (item_i.operation),
  .res_valid_i     (result_o.valid),
  .res_ready_i     (result_o.ready),
  .res_status_i    (result_o.status),
  .res_index_i     (result_o.found_index),
  .res_value_zero_i(result_o.found_value == '0)
);
